// ===== design/assert_macros.svh =====
// Assertion macros for the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/psc_pkg.sv =====
// Package for the PID speed controller: widths, register map and datapath helpers.
`timescale 1ns / 1ps

package psc_pkg;

  localparam int unsigned SpeedW = 24;  // Q12.12 speed and command
  localparam int unsigned GainW  = 16;  // Q8.8 gain
  localparam int unsigned LimW   = 23;  // symmetric clamp magnitude
  localparam int unsigned ErrW   = 25;  // target - measured
  localparam int unsigned DiffW  = 26;  // error - last error
  localparam int unsigned Kd100W = 23;  // kd * 100
  localparam int unsigned WideW  = 49;  // widest product (Kd100W + DiffW)
  localparam int unsigned QuotW  = WideW - 8;
  localparam int unsigned SumW   = 26;  // sum of three terms
  localparam int unsigned IdxW   = 4;
  localparam int unsigned WdataW = 24;

  localparam logic [LimW-1:0]          LimReset   = 23'h7F_FFFF;
  localparam logic signed [SpeedW-1:0] UpperReset = 24'sh7F_FFFF;
  localparam logic signed [SpeedW-1:0] LowerReset = 24'sh80_0000;

  typedef enum logic [IdxW-1:0] {
    REG_KP_GAIN     = 4'd0,
    REG_KI_GAIN     = 4'd1,
    REG_KD_GAIN     = 4'd2,
    REG_PROP_LIMIT  = 4'd3,
    REG_INTEG_LIMIT = 4'd4,
    REG_DERIV_LIMIT = 4'd5,
    REG_OUT_UPPER   = 4'd6,
    REG_OUT_LOWER   = 4'd7
  } cfg_reg_e;

  // Divide by 256, rounding toward zero.
  function automatic logic signed [QuotW-1:0] div256_tz(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] tmp;
    tmp = v + {{(WideW-8){1'b0}}, {8{v[WideW-1]}}};
    return tmp[WideW-1:8];
  endfunction

  // Clamp to +/- lim; the result always fits a speed word.
  function automatic logic signed [SpeedW-1:0] clamp_sym(input logic signed [WideW-1:0] v,
                                                         input logic [LimW-1:0] lim);
    logic signed [WideW-1:0] limp;
    logic signed [WideW-1:0] limn;
    limp = $signed({{(WideW-LimW){1'b0}}, lim});
    limn = -limp;
    if (v > limp) begin
      return $signed({1'b0, lim});
    end else if (v < limn) begin
      return -$signed({1'b0, lim});
    end
    return v[SpeedW-1:0];
  endfunction

endpackage

// ===== design/pid_speed_controller_core.sv =====
// PID speed controller core: error, clamped P/I/D terms and bounded drive command.
// An accepted transaction passes the input, product, term and command registers in turn.
// Throughput: one transaction per cycle; the four register ranks advance together
// whenever the output register is empty or being taken, so a stalled output holds all.
// Reset: gains 0, limits full scale, full output range, last error and integral zero.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pid_speed_controller_core
  import psc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes
  input  logic                     cfg_we_i,
  input  logic [IdxW-1:0]          cfg_idx_i,
  input  logic [WdataW-1:0]        cfg_wdata_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [SpeedW-1:0] target_speed_i,
  input  logic signed [SpeedW-1:0] measured_speed_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [SpeedW-1:0] drive_command_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers. kd is held pre-scaled by 100 (the 0.01 s period),
  // which is exact since kd * (diff * 100) == (kd * 100) * diff.
  // ---------------------------------------------------------------------------
  logic signed [GainW-1:0]  kp_q, ki_q;
  logic signed [Kd100W-1:0] kd100_q;
  logic [LimW-1:0]          prop_lim_q, integ_lim_q, deriv_lim_q;
  logic signed [SpeedW-1:0] out_upper_q, out_lower_q;
  logic signed [Kd100W-1:0] kd_ext;
  logic signed [Kd100W-1:0] kd100_d;

  assign kd_ext  = {{(Kd100W-GainW){cfg_wdata_i[GainW-1]}}, cfg_wdata_i[GainW-1:0]};
  // 100 = 64 + 32 + 4
  assign kd100_d = (kd_ext <<< 6) + (kd_ext <<< 5) + (kd_ext <<< 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= '0;
      ki_q        <= '0;
      kd100_q     <= '0;
      prop_lim_q  <= LimReset;
      integ_lim_q <= LimReset;
      deriv_lim_q <= LimReset;
      out_upper_q <= UpperReset;
      out_lower_q <= LowerReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KP_GAIN:     kp_q        <= cfg_wdata_i[GainW-1:0];
        REG_KI_GAIN:     ki_q        <= cfg_wdata_i[GainW-1:0];
        REG_KD_GAIN:     kd100_q     <= kd100_d;
        REG_PROP_LIMIT:  prop_lim_q  <= cfg_wdata_i[LimW-1:0];
        REG_INTEG_LIMIT: integ_lim_q <= cfg_wdata_i[LimW-1:0];
        REG_DERIV_LIMIT: deriv_lim_q <= cfg_wdata_i[LimW-1:0];
        REG_OUT_UPPER:   out_upper_q <= cfg_wdata_i[SpeedW-1:0];
        REG_OUT_LOWER:   out_lower_q <= cfg_wdata_i[SpeedW-1:0];
        default: ;  // indexes past the map are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: one shared advance for all ranks.
  // ---------------------------------------------------------------------------
  logic advance;
  logic in_acc;
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;
  assign in_acc     = in_valid_i && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_acc;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Rank 1: input register. Error, error step and the three products.
  // last_error moves with each transaction leaving this rank.
  // ---------------------------------------------------------------------------
  logic signed [SpeedW-1:0] target_q, measured_q;
  logic signed [ErrW-1:0]   err_d, last_err_q;
  logic signed [DiffW-1:0]  diff_d;
  logic signed [ErrW+GainW-1:0]    p_prod_d, i_prod_d;
  logic signed [DiffW+Kd100W-1:0]  d_prod_d;
  logic signed [ErrW+GainW-1:0]    p_prod_q, i_prod_q;
  logic signed [DiffW+Kd100W-1:0]  d_prod_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      target_q   <= target_speed_i;
      measured_q <= measured_speed_i;
    end
  end

  assign err_d    = {target_q[SpeedW-1], target_q} - {measured_q[SpeedW-1], measured_q};
  assign diff_d   = {err_d[ErrW-1], err_d} - {last_err_q[ErrW-1], last_err_q};
  assign p_prod_d = kp_q * err_d;
  assign i_prod_d = ki_q * err_d;
  assign d_prod_d = kd100_q * diff_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else if (advance && s1_valid_q) begin
      last_err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p_prod_q <= p_prod_d;
      i_prod_q <= i_prod_d;
      d_prod_q <= d_prod_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Rank 2: scale to Q12.12 (toward zero), accumulate and clamp each term.
  // The clamped integral is written back as the running integral.
  // ---------------------------------------------------------------------------
  localparam int unsigned PExt = WideW - (ErrW + GainW);

  logic signed [QuotW-1:0]  pq_d, iq_d, dq_d;
  logic signed [WideW-1:0]  i_acc_d;
  logic signed [SpeedW-1:0] p_term_d, i_term_d, d_term_d;
  logic signed [SpeedW-1:0] integ_q;
  logic signed [SpeedW-1:0] p_term_q, i_term_q, d_term_q;

  assign pq_d = div256_tz({{PExt{p_prod_q[ErrW+GainW-1]}}, p_prod_q});
  assign iq_d = div256_tz({{PExt{i_prod_q[ErrW+GainW-1]}}, i_prod_q});
  assign dq_d = div256_tz(d_prod_q);

  assign i_acc_d = {{(WideW-SpeedW){integ_q[SpeedW-1]}}, integ_q}
                 + {{(WideW-QuotW){iq_d[QuotW-1]}}, iq_d};

  assign p_term_d = clamp_sym({{(WideW-QuotW){pq_d[QuotW-1]}}, pq_d}, prop_lim_q);
  assign i_term_d = clamp_sym(i_acc_d, integ_lim_q);
  assign d_term_d = clamp_sym({{(WideW-QuotW){dq_d[QuotW-1]}}, dq_d}, deriv_lim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (advance && s2_valid_q) begin
      integ_q <= i_term_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p_term_q <= p_term_d;
      i_term_q <= i_term_d;
      d_term_q <= d_term_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Rank 3: sum and bound. Upper bound is tested first, so crossed bounds
  // resolve to out_upper when above it.
  // ---------------------------------------------------------------------------
  logic signed [SumW-1:0]   sum_d, upper_ext, lower_ext;
  logic signed [SpeedW-1:0] cmd_d, cmd_q;

  assign sum_d = {{(SumW-SpeedW){p_term_q[SpeedW-1]}}, p_term_q}
               + {{(SumW-SpeedW){i_term_q[SpeedW-1]}}, i_term_q}
               + {{(SumW-SpeedW){d_term_q[SpeedW-1]}}, d_term_q};
  assign upper_ext = {{(SumW-SpeedW){out_upper_q[SpeedW-1]}}, out_upper_q};
  assign lower_ext = {{(SumW-SpeedW){out_lower_q[SpeedW-1]}}, out_lower_q};

  always_comb begin
    if (sum_d > upper_ext) begin
      cmd_d = out_upper_q;
    end else if (sum_d < lower_ext) begin
      cmd_d = out_lower_q;
    end else begin
      cmd_d = sum_d[SpeedW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cmd_q <= cmd_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_command_o = cmd_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ASSERT_NEXT(a_acc_lands_s1, clk_i, rst_ni, in_acc, s1_valid_q,
               "accepted transaction did not reach rank 1")
  `ASSERT_NEXT(a_integ_holds, clk_i, rst_ni, !(advance && s2_valid_q), $stable(integ_q),
               "integral moved without a transaction")
  `ASSERT_NEXT(a_freeze_terms, clk_i, rst_ni, out_valid_q && out_stall_i,
               $stable(p_term_q) && $stable(i_term_q) && $stable(d_term_q),
               "term rank moved while output stalled")
  `ASSERT_IMPL(a_out_from_s3, clk_i, rst_ni, $rose(out_valid_q), $past(s3_valid_q),
               "output valid without a transaction in rank 3")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the PID speed controller core.
`timescale 1ns / 1ps

module testbench;
  import psc_pkg::*;

  typedef struct {
    logic signed [SpeedW-1:0] target;
    logic signed [SpeedW-1:0] measured;
  } speed_sample_t;

  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     cfg_we_i         = 1'b0;
  logic [IdxW-1:0]          cfg_idx_i        = '0;
  logic [WdataW-1:0]        cfg_wdata_i      = '0;
  logic                     in_valid_i       = 1'b0;
  logic                     in_stall_o;
  logic signed [SpeedW-1:0] target_speed_i   = '0;
  logic signed [SpeedW-1:0] measured_speed_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i      = 1'b0;
  logic signed [SpeedW-1:0] drive_command_o;

  pid_speed_controller_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .target_speed_i   (target_speed_i),
    .measured_speed_i (measured_speed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_command_o  (drive_command_o)
  );

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  // Controller state as the testbench sees it: registers, last error, integral.
  logic signed [GainW-1:0]  kp_q        = '0;
  logic signed [GainW-1:0]  ki_q        = '0;
  logic signed [GainW-1:0]  kd_q        = '0;
  logic [LimW-1:0]          prop_lim_q  = LimReset;
  logic [LimW-1:0]          integ_lim_q = LimReset;
  logic [LimW-1:0]          deriv_lim_q = LimReset;
  logic signed [SpeedW-1:0] upper_q     = UpperReset;
  logic signed [SpeedW-1:0] lower_q     = LowerReset;
  longint                   prev_error  = 0;
  longint                   integ_acc   = 0;

  speed_sample_t            pending_samples[$];
  logic signed [SpeedW-1:0] expected_commands[$];
  int unsigned              mismatch_count = 0;
  int unsigned              burst_left = 1;
  int unsigned              gap_left = 0;
  int unsigned              stall_cycle = 0;
  int unsigned              stall_mode = 0;

  function automatic longint clamp_term(longint v, logic [LimW-1:0] lim);
    longint mag;
    mag = longint'(lim);
    if (v > mag) return mag;
    if (v < -mag) return -mag;
    return v;
  endfunction

  // One control step; products are exact, then divided by 256 toward zero.
  function automatic logic signed [SpeedW-1:0] predict_drive_command(speed_sample_t s);
    longint err, p_term, i_term, d_term, sum;
    err    = longint'(s.target) - longint'(s.measured);
    p_term = (longint'(kp_q) * err) / 256;
    i_term = integ_acc + (longint'(ki_q) * err) / 256;
    d_term = (longint'(kd_q) * ((err - prev_error) * 100)) / 256;
    prev_error = err;
    p_term = clamp_term(p_term, prop_lim_q);
    i_term = clamp_term(i_term, integ_lim_q);
    d_term = clamp_term(d_term, deriv_lim_q);
    integ_acc = i_term;
    sum = p_term + i_term + d_term;
    // upper bound wins when the bounds are crossed
    if (sum > longint'(upper_q)) sum = longint'(upper_q);
    else if (sum < longint'(lower_q)) sum = longint'(lower_q);
    return sum[SpeedW-1:0];
  endfunction

  function automatic logic signed [SpeedW-1:0] pick_speed();
    longint v;
    case ($urandom_range(0, 7))
      0: v = 8388607;
      1: v = -8388608;
      2: v = 0;
      3, 4: v = longint'($urandom_range(0, 16383)) - 8192;
      default: v = longint'($urandom);
    endcase
    return v[SpeedW-1:0];
  endfunction

  function automatic logic signed [GainW-1:0] pick_gain();
    longint v;
    case ($urandom_range(0, 6))
      0: v = 32767;
      1: v = -32768;
      2: v = 0;
      3, 4, 5: v = longint'($urandom_range(0, 2047)) - 1024;
      default: v = longint'($urandom);
    endcase
    return v[GainW-1:0];
  endfunction

  function automatic logic [LimW-1:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return LimReset;
      2, 3: return LimW'($urandom_range(0, 1 << 16));
      default: return LimW'($urandom_range(0, LimReset));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [WdataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_KP_GAIN:     kp_q        = data[GainW-1:0];
      REG_KI_GAIN:     ki_q        = data[GainW-1:0];
      REG_KD_GAIN:     kd_q        = data[GainW-1:0];
      REG_PROP_LIMIT:  prop_lim_q  = data[LimW-1:0];
      REG_INTEG_LIMIT: integ_lim_q = data[LimW-1:0];
      REG_DERIV_LIMIT: deriv_lim_q = data[LimW-1:0];
      REG_OUT_UPPER:   upper_q     = data;
      REG_OUT_LOWER:   lower_q     = data;
      default: ;  // unmapped index, nothing changes
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Writes all eight registers; unused high data bits carry junk.
  task automatic apply_settings(input logic signed [GainW-1:0] kp, ki, kd,
                                input logic [LimW-1:0] pl, il, dl,
                                input logic signed [SpeedW-1:0] up, lo);
    logic [WdataW-1:0] junk;
    junk = WdataW'($urandom);
    write_reg(REG_KP_GAIN,     {junk[23:16], kp});
    write_reg(REG_KI_GAIN,     {junk[15:8], ki});
    write_reg(REG_KD_GAIN,     {junk[7:0], kd});
    write_reg(REG_PROP_LIMIT,  {junk[23], pl});
    write_reg(REG_INTEG_LIMIT, {junk[12], il});
    write_reg(REG_DERIV_LIMIT, {junk[3], dl});
    write_reg(REG_OUT_UPPER,   up);
    write_reg(REG_OUT_LOWER,   lo);
    @(negedge clk_i);
  endtask

  task automatic queue_sample(input logic signed [SpeedW-1:0] t, m);
    speed_sample_t s;
    s.target   = t;
    s.measured = m;
    pending_samples.push_back(s);
  endtask

  // Idle means nothing queued, nothing offered and no command outstanding.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || expected_commands.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin : sample_driver
    speed_sample_t s;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        s.target   = target_speed_i;
        s.measured = measured_speed_i;
        expected_commands.push_back(predict_drive_command(s));
      end
      if (in_valid_i && in_stall_o) begin
        // stalled transaction holds its payload
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        s = pending_samples.pop_front();
        in_valid_i       <= 1'b1;
        target_speed_i   <= s.target;
        measured_speed_i <= s.measured;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: checks each taken command in order; its stall pattern is re-picked at random.
  always @(posedge clk_i) begin : command_monitor
    logic signed [SpeedW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_commands.size() == 0) begin
        report_mismatch($sformatf("drive command %0d with nothing outstanding",
                                  drive_command_o));
      end else begin
        want = expected_commands.pop_front();
        if (drive_command_o !== want)
          report_mismatch($sformatf("drive command got %0d want %0d", drive_command_o, want));
      end
    end
    stall_cycle++;
    if (stall_cycle % 64 == 0) stall_mode = $urandom_range(0, 4);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      3: out_stall_i <= stall_cycle[0];
      default: out_stall_i <= stall_cycle[3] & stall_cycle[2];
    endcase
  end

  initial begin : stimulus
    logic signed [SpeedW-1:0] aim;
    logic signed [SpeedW-1:0] up;
    logic signed [SpeedW-1:0] lo;
    logic signed [SpeedW-1:0] swap;
    logic [IdxW-1:0]          bad_idx;
    logic [WdataW-1:0]        bad_data;
    longint                   drift;
    longint                   spread;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset values: zero gains give a zero command whatever the speeds.
    queue_sample(24'sh7F_FFFF, 24'sh80_0000);
    queue_sample(24'sh80_0000, 24'sh7F_FFFF);
    queue_sample('0, '0);
    wait_idle();

    // Extreme gains, full limits and bounds, extreme speeds.
    apply_settings(16'sh7FFF, 16'sh8000, 16'sh7FFF, LimReset, LimReset, LimReset,
                   24'sh7F_FFFF, 24'sh80_0000);
    queue_sample(24'sh7F_FFFF, 24'sh80_0000);
    queue_sample(24'sh80_0000, 24'sh7F_FFFF);
    queue_sample('0, '0);
    queue_sample(24'sh7F_FFFF, 24'sh7F_FFFF);
    queue_sample(24'sh80_0000, 24'sh80_0000);
    queue_sample(24'sh12_3456, 24'shF5_4322);
    wait_idle();

    // Zero P and D limits, crossed output bounds, writes to unmapped indexes.
    apply_settings(16'sh0100, 16'sh0080, 16'shFF00, '0, 23'h00_1000, '0,
                   24'shFF_FC18, 24'sh00_03E8);
    write_reg(4'd8, 24'h12_3456);
    write_reg(4'd11, 24'h00_0000);
    write_reg(4'd15, 24'h00_0000);
    @(negedge clk_i);
    queue_sample(24'sh00_1000, '0);
    queue_sample('0, 24'sh00_1000);
    queue_sample(24'sh7F_FFFF, 24'sh80_0000);
    queue_sample(24'sh80_0000, 24'sh7F_FFFF);
    queue_sample(24'shFF_E000, 24'sh00_0064);
    queue_sample(24'sh00_01F4, 24'sh00_01F4);
    wait_idle();

    // Opposite gain extremes, zero integral limit, bounds crossed at full scale.
    apply_settings(16'sh8000, 16'sh7FFF, 16'sh8000, LimReset, '0, LimReset,
                   24'sh80_0000, 24'sh7F_FFFF);
    queue_sample(24'sh7F_FFFF, 24'sh80_0000);
    queue_sample(24'sh80_0000, 24'sh7F_FFFF);
    queue_sample(24'sh00_0001, '0);
    queue_sample('0, 24'sh00_0001);
    queue_sample(24'sh40_0000, 24'shC0_0000);
    wait_idle();

    // Random settings; most samples track a set point with a small error so the
    // integral winds up.
    repeat (12) begin
      up = pick_speed();
      lo = pick_speed();
      if ($urandom_range(0, 3) != 0 && lo > up) begin
        swap = up;
        up   = lo;
        lo   = swap;
      end
      apply_settings(pick_gain(), pick_gain(), pick_gain(),
                     pick_limit(), pick_limit(), pick_limit(), up, lo);
      if ($urandom_range(0, 1) == 1) begin
        bad_idx  = IdxW'($urandom_range(8, 15));
        bad_data = WdataW'($urandom);
        write_reg(bad_idx, bad_data);
        @(negedge clk_i);
      end
      aim = pick_speed();
      for (int n = 0; n < 130; n++) begin
        if (n % 20 == 19) aim = pick_speed();
        if ($urandom_range(0, 4) == 0) begin
          queue_sample(pick_speed(), pick_speed());
        end else begin
          spread = longint'(1) << $urandom_range(0, 14);
          drift  = longint'(aim) + longint'($urandom_range(0, 32'(2 * spread))) - spread;
          if (drift > 8388607) drift = 8388607;
          else if (drift < -8388608) drift = -8388608;
          queue_sample(aim, drift[SpeedW-1:0]);
        end
      end
      wait_idle();
    end

    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && expected_commands.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
